// ----- src/sek_pkg.sv -----
// sek_pkg: word types, register indexes and widths shared by the
// squared exponential kernel block. No dependencies.
`timescale 1ns / 1ps
package sek_pkg;

	localparam int SUM_W = 40;
	localparam int DVD_W = 82;
	localparam int DVS_W = 48;
	localparam int DCNT_W = 7;

	localparam logic REG_AMPLITUDE = 1'b0;
	localparam logic REG_LENGTH_SCALE = 1'b1;

	typedef struct packed {
		logic signed [15:0] coord_a;
		logic signed [15:0] coord_b;
		logic last_coord;
	} item_t;

	typedef struct packed {
		logic [15:0] kernel_value;
		logic [16:0] grad_wrt_amplitude;
		logic [23:0] grad_wrt_length;
	} result_t;

	typedef struct packed {
		logic start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
		logic [DCNT_W-1:0] nbits;
	} div_req_t;

endpackage

// ----- src/sek_div.sv -----
// sek_div: bit-serial restoring divider, one quotient bit per cycle.
// Depends on sek_pkg.
`timescale 1ns / 1ps
module sek_div import sek_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  div_req_t req,
	output logic done,
	output logic [DVD_W-1:0] quotient
);

	logic busy_q;
	logic done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W:0] rem_sh;
	logic ge;

	assign rem_sh = {rem_q, dvd_q[cnt_q]};
	assign ge = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? DVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end else if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			cnt_q <= req.nbits - 1'b1;
			rem_q <= '0;
			quo_q <= '0;
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/sek_front.sv -----
// sek_front: takes coordinate words, squares the difference and sums
// the squared distance per point pair. Depends on sek_pkg.
`timescale 1ns / 1ps
module sek_front import sek_pkg::*; #(
	parameter int MAX_DIM = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  item_t item,
	input  logic q_full,
	output logic q_push,
	output logic [SUM_W-1:0] q_data
);

	localparam int CW = $clog2(MAX_DIM + 1);

	logic s1_vld_q;
	logic [31:0] sq_s1;
	logic last_s1;
	logic [SUM_W-1:0] sum_q;
	logic [CW-1:0] cnt_q;
	logic adv;
	logic take;
	logic signed [16:0] diff;
	logic [15:0] ad;
	logic room;
	logic [SUM_W:0] sum_add;
	logic [SUM_W-1:0] sum_new;

	assign adv = !s1_vld_q || !(last_s1 && q_full);
	assign item_stall = !adv;
	assign take = item_valid && adv;

	assign diff = 17'(item.coord_a) - 17'(item.coord_b);
	assign ad = diff[16] ? 16'(-diff) : diff[15:0];

	assign room = cnt_q < CW'(MAX_DIM);
	assign sum_add = {1'b0, sum_q} + (SUM_W + 1)'(sq_s1);
	always_comb begin
		if (!room)
			sum_new = sum_q;
		else if (sum_add[SUM_W])
			sum_new = '1;
		else
			sum_new = sum_add[SUM_W-1:0];
	end

	assign q_push = s1_vld_q && adv && last_s1;
	assign q_data = sum_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
			sum_q <= '0;
			cnt_q <= '0;
		end else begin
			s1_vld_q <= take || (s1_vld_q && !adv);
			if (s1_vld_q && adv) begin
				if (last_s1) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_new;
					if (room)
						cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			sq_s1 <= ad * ad;
			last_s1 <= item.last_coord;
		end
	end

endmodule

// ----- src/sek_queue.sv -----
// sek_queue: two-entry queue of squared distances between front and back.
// Depends on sek_pkg.
`timescale 1ns / 1ps
module sek_queue import sek_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [SUM_W-1:0] wdata,
	input  logic pop,
	output logic full,
	output logic nonempty,
	output logic [SUM_W-1:0] rdata
);

	logic [SUM_W-1:0] mem_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

endmodule

// ----- src/sek_back.sv -----
// sek_back: sequencer for exponent, kernel and gradients over one shared
// multiplier and the sek_div divider. Depends on sek_pkg, sek_div.
`timescale 1ns / 1ps
module sek_back import sek_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic [15:0] amplitude,
	input  logic [15:0] length_scale,
	input  logic q_nonempty,
	input  logic [SUM_W-1:0] q_data,
	output logic q_pop,
	output logic result_valid,
	input  logic result_stall,
	output result_t result
);

	typedef enum logic [18:0] {
		S_IDLE   = 19'b0000000000000000001,
		S_L2     = 19'b0000000000000000010,
		S_XSTART = 19'b0000000000000000100,
		S_XDIV   = 19'b0000000000000001000,
		S_TMUL   = 19'b0000000000000010000,
		S_TDIV   = 19'b0000000000000100000,
		S_TWAIT  = 19'b0000000000001000000,
		S_SQ     = 19'b0000000000010000000,
		S_SQW    = 19'b0000000000100000000,
		S_EFIN   = 19'b0000000001000000000,
		S_KMUL   = 19'b0000000010000000000,
		S_KW     = 19'b0000000100000000000,
		S_QDIV   = 19'b0000001000000000000,
		S_NLO    = 19'b0000010000000000000,
		S_NLOW   = 19'b0000100000000000000,
		S_NHI    = 19'b0001000000000000000,
		S_NHIW   = 19'b0010000000000000000,
		S_GDIV   = 19'b0100000000000000000,
		S_OUT    = 19'b1000000000000000000
	} state_t;

	state_t state_q;
	logic [SUM_W-1:0] d_q;
	logic [15:0] l_q;
	logic [31:0] l2_q;
	logic [29:0] t_q;
	logic [31:0] term_q;
	logic [31:0] s_q;
	logic [3:0] k_q;
	logic [2:0] n_q;
	logic [16:0] e_q;
	logic [32:0] ae_q;
	logic [15:0] kv_q;
	logic [23:0] grad_q;
	logic [47:0] qq_q;
	logic [56:0] num_q;
	logic ovld_q;
	result_t res_q;

	logic [31:0] mul_a;
	logic [32:0] mul_b;
	logic [64:0] prod_q;
	logic [64:0] prod_rnd;
	div_req_t dreq;
	logic ddone;
	logic [DVD_W-1:0] quo;
	logic [31:0] term_new;
	logic [32:0] e_sum;
	logic [33:0] kv_sum;
	logic [DVD_W-1:0] num_full;
	logic [32:0] rcp_m;
	logic [5:0] rcp_s;

	sek_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.done(ddone),
		.quotient(quo)
	);

	// term / k as multiply by ceil(2^s / k), exact for a 30-bit term
	always_comb begin
		case (k_q)
			4'd1: begin
				rcp_m = 33'd1073741824;
				rcp_s = 6'd30;
			end
			4'd2: begin
				rcp_m = 33'd1073741824;
				rcp_s = 6'd31;
			end
			4'd3: begin
				rcp_m = 33'd1431655766;
				rcp_s = 6'd32;
			end
			4'd4: begin
				rcp_m = 33'd1073741824;
				rcp_s = 6'd32;
			end
			4'd5: begin
				rcp_m = 33'd1717986919;
				rcp_s = 6'd33;
			end
			4'd6: begin
				rcp_m = 33'd1431655766;
				rcp_s = 6'd33;
			end
			4'd7: begin
				rcp_m = 33'd1227133514;
				rcp_s = 6'd33;
			end
			4'd8: begin
				rcp_m = 33'd1073741824;
				rcp_s = 6'd33;
			end
			4'd9: begin
				rcp_m = 33'd1908874354;
				rcp_s = 6'd34;
			end
			4'd10: begin
				rcp_m = 33'd1717986919;
				rcp_s = 6'd34;
			end
			4'd11: begin
				rcp_m = 33'd1561806290;
				rcp_s = 6'd34;
			end
			4'd12: begin
				rcp_m = 33'd1431655766;
				rcp_s = 6'd34;
			end
			default: begin
				rcp_m = 33'd1073741824;
				rcp_s = 6'd30;
			end
		endcase
	end

	assign prod_rnd = prod_q + (65'd1 << 29);
	assign e_sum = {1'b0, s_q} + 33'd8192;
	assign kv_sum = {1'b0, prod_q[32:0]} + 34'd32768;
	assign term_new = 32'(prod_q >> rcp_s);
	assign num_full = DVD_W'(num_q) + (DVD_W'(prod_q[56:0]) << 24) + (DVD_W'(l2_q) << 15);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_L2: begin
				mul_a = 32'(l_q);
				mul_b = 33'(l_q);
			end
			S_TMUL: begin
				mul_a = term_q;
				mul_b = 33'(t_q);
			end
			S_TDIV: begin
				mul_a = prod_rnd[61:30];
				mul_b = rcp_m;
			end
			S_SQ: begin
				mul_a = s_q;
				mul_b = 33'(s_q);
			end
			S_KMUL: begin
				mul_a = 32'(amplitude);
				mul_b = 33'(e_q);
			end
			S_NLO: begin
				mul_a = 32'(qq_q[23:0]);
				mul_b = ae_q;
			end
			S_NHI: begin
				mul_a = 32'(qq_q[47:24]);
				mul_b = ae_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		dreq = '0;
		case (state_q)
			S_XSTART: begin
				dreq.start = 1'b1;
				dreq.dividend = DVD_W'(d_q) << 16;
				dreq.divisor = DVS_W'({prod_q[31:0], 1'b0});
				dreq.nbits = DCNT_W'(SUM_W + 16);
			end
			S_KW: begin
				dreq.start = e_q != '0;
				dreq.dividend = DVD_W'(d_q) << 8;
				dreq.divisor = DVS_W'(l_q);
				dreq.nbits = DCNT_W'(SUM_W + 8);
			end
			S_NHIW: begin
				dreq.start = 1'b1;
				dreq.dividend = num_full;
				dreq.divisor = DVS_W'(l2_q) << 16;
				dreq.nbits = DCNT_W'(DVD_W);
			end
			default: dreq = '0;
		endcase
	end

	assign q_pop = (state_q == S_IDLE) && q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ovld_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && (!ovld_q || !result_stall))
				ovld_q <= 1'b1;
			else if (!result_stall)
				ovld_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_nonempty) state_q <= S_L2;
				S_L2: state_q <= S_XSTART;
				S_XSTART: state_q <= S_XDIV;
				S_XDIV: begin
					if (ddone) begin
						if (quo >= (DVD_W'(17) << 16))
							state_q <= S_KMUL;
						else
							state_q <= S_TMUL;
					end
				end
				S_TMUL: state_q <= S_TDIV;
				S_TDIV: state_q <= S_TWAIT;
				S_TWAIT: state_q <= (k_q == 4'd12) ? S_SQ : S_TMUL;
				S_SQ: state_q <= S_SQW;
				S_SQW: state_q <= (n_q == 3'd4) ? S_EFIN : S_SQ;
				S_EFIN: state_q <= S_KMUL;
				S_KMUL: state_q <= S_KW;
				S_KW: state_q <= (e_q == '0) ? S_OUT : S_QDIV;
				S_QDIV: if (ddone) state_q <= S_NLO;
				S_NLO: state_q <= S_NLOW;
				S_NLOW: state_q <= S_NHI;
				S_NHI: state_q <= S_NHIW;
				S_NHIW: state_q <= S_GDIV;
				S_GDIV: if (ddone) state_q <= S_OUT;
				S_OUT: if (!ovld_q || !result_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			S_IDLE: begin
				d_q <= q_data;
				l_q <= (length_scale == '0) ? 16'd1 : length_scale;
			end
			S_XSTART: l2_q <= prod_q[31:0];
			S_XDIV: begin
				e_q <= '0;
				t_q <= {quo[20:0], 9'b0};
				s_q <= 32'd1 << 30;
				term_q <= 32'd1 << 30;
				k_q <= 4'd1;
			end
			S_TWAIT: begin
				term_q <= term_new;
				if (k_q[0])
					s_q <= (s_q >= term_new) ? s_q - term_new : '0;
				else
					s_q <= s_q + term_new;
				k_q <= k_q + 4'd1;
				n_q <= '0;
			end
			S_SQW: begin
				s_q <= prod_rnd[61:30];
				n_q <= n_q + 3'd1;
			end
			S_EFIN: e_q <= (e_sum[32:14] > 19'd65536) ? 17'd65536 : e_sum[30:14];
			S_KW: begin
				ae_q <= prod_q[32:0];
				kv_q <= (kv_sum[33:16] > 18'd65535) ? 16'hFFFF : kv_sum[31:16];
				grad_q <= '0;
			end
			S_QDIV: qq_q <= quo[47:0];
			S_NLOW: num_q <= prod_q[56:0];
			S_GDIV: grad_q <= (quo > DVD_W'(24'hFFFFFF)) ? 24'hFFFFFF : quo[23:0];
			S_OUT: begin
				if (!ovld_q || !result_stall) begin
					res_q.kernel_value <= kv_q;
					res_q.grad_wrt_amplitude <= e_q;
					res_q.grad_wrt_length <= grad_q;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = ovld_q;
	assign result = res_q;

endmodule

// ----- src/sq_exp_kernel_with_gradient_unit.sv -----
// Squared exponential kernel with amplitude and length-scale gradients.
// Front: one coordinate word per cycle unless the queue is full; the squares are
// registered and each pair's sum is pushed from that register. Back: the divider takes
// 56, 48 and 82 steps (only the first if the exponent underflows); series terms share
// one multiplier. A two-word queue parts front and back; the result is registered.
// Reset clears sums, queue, sequencer; amplitude and length_scale reset to 1.0.
`timescale 1ns / 1ps
module sq_exp_kernel_with_gradient_unit import sek_pkg::*; #(
	parameter int MAX_DIM = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_stall,
	input  item_t item,
	output logic result_valid,
	input  logic result_stall,
	output result_t result,
	input  logic wr_en,
	input  logic wr_index,
	input  logic [15:0] wr_data
);

	logic [15:0] amp_q;
	logic [15:0] ls_q;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_nonempty;
	logic [SUM_W-1:0] q_wdata;
	logic [SUM_W-1:0] q_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q <= 16'd256;
			ls_q <= 16'd256;
		end else if (wr_en) begin
			case (wr_index)
				REG_AMPLITUDE: amp_q <= wr_data;
				REG_LENGTH_SCALE: ls_q <= wr_data;
				default: ;
			endcase
		end
	end

	sek_front #(.MAX_DIM(MAX_DIM)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.q_full(q_full),
		.q_push(q_push),
		.q_data(q_wdata)
	);

	sek_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.pop(q_pop),
		.full(q_full),
		.nonempty(q_nonempty),
		.rdata(q_rdata)
	);

	sek_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.amplitude(amp_q),
		.length_scale(ls_q),
		.q_nonempty(q_nonempty),
		.q_data(q_rdata),
		.q_pop(q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

endmodule
